@@ design/akmq_pkg.sv @@
// Shared types, sizes and codes of the aging keyed MAC queue.
// No dependencies; the unit, the sequencer and the datapath use this package.
`timescale 1ns / 1ps

package akmq_pkg;

   localparam int DEPTH = 1024;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] MIN_CAPACITY = CW'(100);
   localparam logic [CW-1:0] DEPTH_CAP = CW'(DEPTH);
   localparam logic [CW-1:0] RESET_CAPACITY = CW'(400);

   localparam logic [3:0] ACT_ENQ = 4'd0;
   localparam logic [3:0] ACT_FRONT = 4'd1;
   localparam logic [3:0] ACT_DEQ = 4'd2;
   localparam logic [3:0] ACT_PEEK = 4'd3;
   localparam logic [3:0] ACT_DEQ_TA = 4'd4;
   localparam logic [3:0] ACT_PEEK_TA = 4'd5;
   localparam logic [3:0] ACT_DEQ_A = 4'd6;
   localparam logic [3:0] ACT_PEEK_A = 4'd7;
   localparam logic [3:0] ACT_CNT_T = 4'd8;
   localparam logic [3:0] ACT_CNT_I = 4'd9;
   localparam logic [3:0] ACT_REMOVE = 4'd10;
   localparam logic [3:0] ACT_FLUSH = 4'd11;
   localparam logic [3:0] ACT_SIZE = 4'd12;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [1:0] CSR_MAX_DELAY = 2'd0;
   localparam logic [1:0] CSR_INIT_CAP = 2'd1;
   localparam logic [1:0] CSR_HOLD = 2'd2;

   localparam logic [1:0] SEL_ADDR1 = 2'd0;
   localparam logic [1:0] SEL_ADDR2 = 2'd1;
   localparam logic [1:0] SEL_ADDR3 = 2'd2;
   localparam logic [1:0] SEL_ZERO = 2'd3;

   typedef struct packed {
      logic [31:0] handle;
      logic        is_qos;
      logic [3:0]  tid;
      logic [47:0] addr1;
      logic [47:0] addr2;
      logic [47:0] addr3;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [47:0] stamp;
   } entry_type;

   localparam int EW = $bits(entry_type);

   typedef struct packed {
      logic [3:0]  action;
      logic [47:0] now;
      logic [31:0] handle;
      logic        is_qos;
      logic [3:0]  tid;
      logic [47:0] addr1;
      logic [47:0] addr2;
      logic [47:0] addr3;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [1:0]  addr_sel;
      logic [47:0] key_addr;
   } req_item_type;

   typedef struct packed {
      logic [1:0]    status;
      entry_type     entry;
      logic [CW-1:0] match_count;
      logic [CW-1:0] capacity_now;
   } rsp_item_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic rd;
      logic eval;
      logic walk_end;
      logic resize;
      logic store;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walk_needed;
      logic walk_done;
      logic need_resize;
      logic need_store;
      logic out_free;
   } stat_type;

   function automatic logic [CW-1:0] clamp_cap(input logic [CW:0] v);
      logic [CW-1:0] r;
      if (v == '0) r = CW'(1);
      else if (v > {1'b0, DEPTH_CAP}) r = DEPTH_CAP;
      else r = v[CW-1:0];
      return r;
   endfunction

endpackage

@@ design/akmq_req_if.sv @@
// Request channel of the queue: valid/ready handshake and the request fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface akmq_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [47:0] now;
   logic [31:0] handle;
   logic        is_qos;
   logic [3:0]  tid;
   logic [47:0] addr1;
   logic [47:0] addr2;
   logic [47:0] addr3;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [1:0]  addr_sel;
   logic [47:0] key_addr;

   modport source(output valid, action, now, handle, is_qos, tid, addr1, addr2, addr3,
                  src_ip, dst_ip, addr_sel, key_addr, input ready);
   modport sink(input valid, action, now, handle, is_qos, tid, addr1, addr2, addr3,
                src_ip, dst_ip, addr_sel, key_addr, output ready);
endinterface

@@ design/akmq_rsp_if.sv @@
// Response channel of the queue: valid/ready handshake and the result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface akmq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] out_handle;
   logic        out_is_qos;
   logic [3:0]  out_tid;
   logic [47:0] out_addr1;
   logic [47:0] out_addr2;
   logic [47:0] out_addr3;
   logic [31:0] out_src_ip;
   logic [31:0] out_dst_ip;
   logic [47:0] out_stamp;
   logic [10:0] match_count;
   logic [10:0] capacity_now;

   modport source(output valid, status, out_handle, out_is_qos, out_tid, out_addr1,
                  out_addr2, out_addr3, out_src_ip, out_dst_ip, out_stamp, match_count,
                  capacity_now, input ready);
   modport sink(input valid, status, out_handle, out_is_qos, out_tid, out_addr1,
                out_addr2, out_addr3, out_src_ip, out_dst_ip, out_stamp, match_count,
                capacity_now, output ready);
endinterface

@@ design/akmq_csr_if.sv @@
// Register write channel of the queue: valid/ready, register index and data.
// Depends on nothing.
`timescale 1ns / 1ps

interface akmq_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ design/aging_keyed_mac_queue_unit.sv @@
// Aging keyed MAC queue: an ordered ring of up to 1024 frame descriptors in one RAM.
// Walking actions (codes 0 to 10) read each entry of the fill in turn, the fill being
// the count before aging; push front adds a store step, enqueue adds a resize and a store.
// Flush, size and unused codes skip the walk. One item is in work at a time and the next
// can be taken in the cycle after the result is loaded, even while that result waits.
// Synchronous active-high reset empties the queue, loads capacity 400 and default
// registers; the RAM is not cleared, since entries beyond the fill are never read.
`timescale 1ns / 1ps

module aging_keyed_mac_queue_unit (
   input logic        clock,
   input logic        reset,
   akmq_req_if.sink   req_if,
   akmq_rsp_if.source rsp_if,
   akmq_csr_if.sink   csr_if
);

   akmq_pkg::cmd_type      cmd;
   akmq_pkg::stat_type     stat;
   akmq_pkg::req_item_type req_item;
   akmq_pkg::rsp_item_type rsp_item;
   logic                   rsp_valid;

   // Collect the request fields into one item for the datapath.
   always_comb begin
      req_item.action = req_if.action;
      req_item.now = req_if.now;
      req_item.handle = req_if.handle;
      req_item.is_qos = req_if.is_qos;
      req_item.tid = req_if.tid;
      req_item.addr1 = req_if.addr1;
      req_item.addr2 = req_if.addr2;
      req_item.addr3 = req_if.addr3;
      req_item.src_ip = req_if.src_ip;
      req_item.dst_ip = req_if.dst_ip;
      req_item.addr_sel = req_if.addr_sel;
      req_item.key_addr = req_if.key_addr;
   end

   // The sequencer owns the request handshake; the datapath does the work.
   akmq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready),
      .stat(stat), .cmd(cmd)
   );

   // Register writes are taken unchecked; the user must send them only while idle.
   assign csr_if.ready = 1'b1;

   akmq_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req_item(req_item),
      .csr_valid(csr_if.valid), .csr_index(csr_if.index), .csr_data(csr_if.data),
      .rsp_ready(rsp_if.ready), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   // The result register drives the response channel directly.
   assign rsp_if.valid = rsp_valid;
   assign rsp_if.status = rsp_item.status;
   assign rsp_if.out_handle = rsp_item.entry.handle;
   assign rsp_if.out_is_qos = rsp_item.entry.is_qos;
   assign rsp_if.out_tid = rsp_item.entry.tid;
   assign rsp_if.out_addr1 = rsp_item.entry.addr1;
   assign rsp_if.out_addr2 = rsp_item.entry.addr2;
   assign rsp_if.out_addr3 = rsp_item.entry.addr3;
   assign rsp_if.out_src_ip = rsp_item.entry.src_ip;
   assign rsp_if.out_dst_ip = rsp_item.entry.dst_ip;
   assign rsp_if.out_stamp = rsp_item.entry.stamp;
   assign rsp_if.match_count = rsp_item.match_count;
   assign rsp_if.capacity_now = rsp_item.capacity_now;

endmodule

@@ design/akmq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module akmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/akmq_ctrl.sv @@
// Sequencer of the queue: accepts a request, runs the entry walk, resize,
// store and result steps. Depends on akmq_pkg.
`timescale 1ns / 1ps

module akmq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  akmq_pkg::stat_type stat,
   output akmq_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_CHK  = 7'b0000010,
      S_RD   = 7'b0000100,
      S_EV   = 7'b0001000,
      S_RSZ  = 7'b0010000,
      S_STO  = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            cmd.start = 1'b1;
            state_in = stat.walk_needed ? S_RD : S_FIN;
         end
         S_RD: begin
            if (stat.walk_done) begin
               cmd.walk_end = 1'b1;
               if (stat.need_resize) state_in = S_RSZ;
               else if (stat.need_store) state_in = S_STO;
               else state_in = S_FIN;
            end else begin
               cmd.rd = 1'b1;
               state_in = S_EV;
            end
         end
         S_EV: begin
            cmd.eval = 1'b1;
            state_in = S_RD;
         end
         S_RSZ: begin
            cmd.resize = 1'b1;
            state_in = S_STO;
         end
         S_STO: begin
            cmd.store = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

@@ design/akmq_dp.sv @@
// Datapath of the queue: entry ring in RAM, walk with aging and compaction,
// capacity control, registers and the result register. Depends on akmq_pkg, akmq_ram.
`timescale 1ns / 1ps

module akmq_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  akmq_pkg::cmd_type      cmd,
   output akmq_pkg::stat_type     stat,
   input  akmq_pkg::req_item_type req_item,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [47:0]            csr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output akmq_pkg::rsp_item_type rsp_item
);

   localparam int AW = akmq_pkg::AW;
   localparam int CW = akmq_pkg::CW;

   akmq_pkg::req_item_type rq_ff;
   logic [AW-1:0] head_ff;
   logic [CW-1:0] count_ff, idx_ff, kept_ff, mcount_ff, cap_ff;
   logic          found_ff, full_ff, timer_on_ff;
   logic [47:0]   since_ff, max_delay_ff, hold_ff;
   akmq_pkg::entry_type hit_ff;
   logic          rsp_valid_ff;
   akmq_pkg::rsp_item_type rsp_ff;

   // RAM ports
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [akmq_pkg::EW-1:0] wr_data, rd_data;
   akmq_pkg::entry_type rd_entry, new_entry;

   akmq_ram #(.WIDTH(akmq_pkg::EW), .DEPTH(akmq_pkg::DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_entry = akmq_pkg::entry_type'(rd_data);

   // Action classes
   logic purge_en, take_act, remove_act, count_act, emit_act;
   always_comb begin
      purge_en = (rq_ff.action <= akmq_pkg::ACT_CNT_I);
      take_act = 1'b0; remove_act = 1'b0; count_act = 1'b0; emit_act = 1'b0;
      case (rq_ff.action) inside
         akmq_pkg::ACT_DEQ, akmq_pkg::ACT_DEQ_TA, akmq_pkg::ACT_DEQ_A: begin
            take_act = 1'b1; remove_act = 1'b1; emit_act = 1'b1;
         end
         akmq_pkg::ACT_PEEK, akmq_pkg::ACT_PEEK_TA, akmq_pkg::ACT_PEEK_A: begin
            take_act = 1'b1; emit_act = 1'b1;
         end
         akmq_pkg::ACT_REMOVE: begin
            take_act = 1'b1; remove_act = 1'b1;
         end
         akmq_pkg::ACT_CNT_T, akmq_pkg::ACT_CNT_I: count_act = 1'b1;
         default: ;
      endcase
   end

   // Evaluation of the entry just read
   logic [47:0] sel_addr;
   logic        aged, qos_addr, tid_eq, ip_eq, is_match, take, drop;
   always_comb begin
      case (rq_ff.addr_sel)
         akmq_pkg::SEL_ADDR1: sel_addr = rd_entry.addr1;
         akmq_pkg::SEL_ADDR2: sel_addr = rd_entry.addr2;
         akmq_pkg::SEL_ADDR3: sel_addr = rd_entry.addr3;
         default:             sel_addr = '0;
      endcase
      aged = purge_en &&
             (({1'b0, rd_entry.stamp} + {1'b0, max_delay_ff}) <= {1'b0, rq_ff.now});
      qos_addr = rd_entry.is_qos && (sel_addr == rq_ff.key_addr);
      tid_eq = (rd_entry.tid == rq_ff.tid);
      ip_eq = (rd_entry.src_ip == rq_ff.src_ip) && (rd_entry.dst_ip == rq_ff.dst_ip);
      case (rq_ff.action) inside
         akmq_pkg::ACT_DEQ, akmq_pkg::ACT_PEEK: is_match = 1'b1;
         akmq_pkg::ACT_DEQ_TA, akmq_pkg::ACT_PEEK_TA: is_match = qos_addr && tid_eq && ip_eq;
         akmq_pkg::ACT_DEQ_A, akmq_pkg::ACT_PEEK_A, akmq_pkg::ACT_CNT_I:
            is_match = qos_addr && ip_eq;
         akmq_pkg::ACT_CNT_T: is_match = qos_addr && tid_eq;
         akmq_pkg::ACT_REMOVE: is_match = (rd_entry.handle == rq_ff.handle);
         default: is_match = 1'b0;
      endcase
      take = take_act && !found_ff && is_match && !aged;
      drop = aged || (take && remove_act);
   end

   // Resize arithmetic
   logic [CW+4:0] fill20, cap19, fill5, cap2;
   logic [47:0]   elapsed;
   logic [CW-1:0] half_cap;
   always_comb begin
      fill20 = {5'b0, count_ff} * (CW+5)'(20);
      cap19 = {5'b0, cap_ff} * (CW+5)'(19);
      fill5 = {5'b0, count_ff} * (CW+5)'(5);
      cap2 = {5'b0, cap_ff} * (CW+5)'(2);
      elapsed = rq_ff.now - since_ff;
      half_cap = cap_ff >> 1;
      if (half_cap < akmq_pkg::MIN_CAPACITY) half_cap = akmq_pkg::MIN_CAPACITY;
   end

   logic full_now;
   assign full_now = (count_ff >= cap_ff) || (count_ff >= akmq_pkg::DEPTH_CAP);

   always_comb begin
      new_entry.handle = rq_ff.handle;
      new_entry.is_qos = rq_ff.is_qos;
      new_entry.tid = rq_ff.tid;
      new_entry.addr1 = rq_ff.addr1;
      new_entry.addr2 = rq_ff.addr2;
      new_entry.addr3 = rq_ff.addr3;
      new_entry.src_ip = rq_ff.src_ip;
      new_entry.dst_ip = rq_ff.dst_ip;
      new_entry.stamp = rq_ff.now;
   end

   always_comb begin
      rd_en = cmd.rd;
      rd_addr = head_ff + idx_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = head_ff + kept_ff[AW-1:0];
      wr_data = rd_data;
      if (cmd.eval && !drop && (kept_ff != idx_ff)) wr_en = 1'b1;
      if (cmd.store && !full_now) begin
         wr_en = 1'b1;
         wr_data = new_entry;
         if (rq_ff.action == akmq_pkg::ACT_FRONT) wr_addr = head_ff - AW'(1);
         else wr_addr = head_ff + count_ff[AW-1:0];
      end
   end

   // Result assembly
   logic [1:0] status_out;
   always_comb begin
      case (rq_ff.action) inside
         akmq_pkg::ACT_ENQ, akmq_pkg::ACT_FRONT:
            status_out = full_ff ? akmq_pkg::ST_FULL : akmq_pkg::ST_DONE;
         akmq_pkg::ACT_DEQ, akmq_pkg::ACT_PEEK, akmq_pkg::ACT_DEQ_TA, akmq_pkg::ACT_PEEK_TA,
         akmq_pkg::ACT_DEQ_A, akmq_pkg::ACT_PEEK_A, akmq_pkg::ACT_REMOVE:
            status_out = found_ff ? akmq_pkg::ST_DONE : akmq_pkg::ST_MISS;
         akmq_pkg::ACT_CNT_T, akmq_pkg::ACT_CNT_I:
            status_out = (mcount_ff != '0) ? akmq_pkg::ST_DONE : akmq_pkg::ST_MISS;
         akmq_pkg::ACT_FLUSH, akmq_pkg::ACT_SIZE: status_out = akmq_pkg::ST_DONE;
         default: status_out = akmq_pkg::ST_MISS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) rq_ff <= req_item;
      if (cmd.start) begin
         idx_ff <= '0;
         kept_ff <= '0;
         found_ff <= 1'b0;
         full_ff <= 1'b0;
         mcount_ff <= '0;
         hit_ff <= '0;
      end
      if (cmd.eval) begin
         if (take) begin
            found_ff <= 1'b1;
            if (emit_act) hit_ff <= rd_entry;
         end
         if (count_act && is_match && !aged) mcount_ff <= mcount_ff + CW'(1);
         if (!drop) kept_ff <= kept_ff + CW'(1);
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.store) full_ff <= full_now;
      if (cmd.finish) begin
         rsp_ff.status <= status_out;
         rsp_ff.entry <= hit_ff;
         rsp_ff.match_count <= count_act ? mcount_ff : count_ff;
         rsp_ff.capacity_now <= cap_ff;
      end
      if (csr_valid && csr_index == akmq_pkg::CSR_MAX_DELAY) max_delay_ff <= csr_data;
      if (csr_valid && csr_index == akmq_pkg::CSR_HOLD) hold_ff <= csr_data;

      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
         cap_ff <= akmq_pkg::RESET_CAPACITY;
         timer_on_ff <= 1'b0;
         since_ff <= '0;
         max_delay_ff <= 48'd10000000;
         hold_ff <= 48'd1000000;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start && rq_ff.action == akmq_pkg::ACT_FLUSH) count_ff <= '0;
         if (cmd.walk_end) count_ff <= kept_ff;
         if (cmd.resize) begin
            if (fill20 >= cap19) begin
               cap_ff <= akmq_pkg::clamp_cap({cap_ff, 1'b0});
            end else if (fill5 < cap2) begin
               if (!timer_on_ff) begin
                  timer_on_ff <= 1'b1;
                  since_ff <= rq_ff.now;
               end else if (elapsed >= hold_ff) begin
                  cap_ff <= akmq_pkg::clamp_cap({1'b0, half_cap});
                  timer_on_ff <= 1'b0;
               end
            end else begin
               timer_on_ff <= 1'b0;
            end
         end
         if (cmd.store && !full_now) begin
            count_ff <= count_ff + CW'(1);
            if (rq_ff.action == akmq_pkg::ACT_FRONT) head_ff <= head_ff - AW'(1);
         end
         if (csr_valid && csr_index == akmq_pkg::CSR_INIT_CAP) begin
            cap_ff <= akmq_pkg::clamp_cap({1'b0, csr_data[CW-1:0]});
         end
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.walk_needed = (rq_ff.action <= akmq_pkg::ACT_REMOVE);
      stat.walk_done = (idx_ff == count_ff);
      stat.need_resize = (rq_ff.action == akmq_pkg::ACT_ENQ);
      stat.need_store = (rq_ff.action == akmq_pkg::ACT_ENQ) ||
                        (rq_ff.action == akmq_pkg::ACT_FRONT);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule
